// ===== src/fdpa_pkg.sv =====
`default_nettype none

package fdpa_pkg;

    // field widths fixed by the pixel stream format
    localparam int unsigned COORD_W  = 5;
    localparam int unsigned COLOR_W  = 2;
    localparam int unsigned CHANCE_W = 7;
    localparam int unsigned SPEED_W  = 5;
    localparam int unsigned MODE_W   = 3;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 7;
    localparam int unsigned IN_TDATA_W  = 16;
    localparam int unsigned OUT_TDATA_W = 16;

    // rain modes
    localparam logic [MODE_W-1:0] MODE_WAIT   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_FIRST  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_SECOND = 3'd2;
    localparam logic [MODE_W-1:0] MODE_THIRD  = 3'd3;

    // colors
    localparam logic [COLOR_W-1:0] COLOR_BLACK = 2'd0;
    localparam logic [COLOR_W-1:0] COLOR_BLUE  = 2'd1;
    localparam logic [COLOR_W-1:0] COLOR_CYAN  = 2'd2;
    localparam logic [COLOR_W-1:0] COLOR_WHITE = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CHANCE_ONE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_ONE    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CHANCE_TWO   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_TWO    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CHANCE_THREE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_THREE  = 3'd5;

    // one pixel request
    typedef struct packed {
        logic               write;
        logic [COLOR_W-1:0] color;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] x;
    } pix_res_t;

endpackage

`default_nettype wire

// ===== src/falling_drop_pixel_animator.sv =====
`default_nettype none

// Falling drop pixel animator.
// Input stream (s_*): one request per animation tick, carrying rain mode,
// a random percent draw and a random spawn column. Output stream (m_*): a
// run of pixel write requests per tick, the final one flagged by m_tlast.
// A tick with nothing to draw yields one marker request (m_tuser = 0).
// cfg_we/cfg_index/cfg_data set chance and speed per rain mode; write only
// while no tick is in flight.
// Sequence: one shared row adder/compare walks the slots; an idle slot is
// passed over, a live drop is cleared, then moved or retired at the bottom
// edge. After a tick is taken, s_tready stays low through the walk, the
// spawn and the flush, stalls included, so no new tick is taken before the
// last is done; the final request is on m_* as s_tready rises again.
// Results pass through a one-deep hold register (so the last can be flagged)
// and the m_* output register; a stalled receiver freezes the sequencer at
// its next pixel, nothing is dropped. The next tick may be accepted while
// the final request still waits in the output register.
// Reset: all drops inactive, registers back to their defaults, no output
// pending. Drop column/row storage is not cleared; it is read only for
// active slots.
module falling_drop_pixel_animator #(
    parameter int DROP_SLOTS  = 16,
    parameter int GRID_WIDTH  = 32,
    parameter int GRID_HEIGHT = 32
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // tdata: rain_mode[2:0], chance_draw[9:3], spawn_column[14:10], zero pad
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [fdpa_pkg::IN_TDATA_W-1:0]    s_tdata,
    // tdata: pixel_x[4:0], pixel_y[9:5], pixel_color[11:10], zero pad
    // tuser: write_valid
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic [fdpa_pkg::OUT_TDATA_W-1:0]        m_tdata,
    output logic                                    m_tuser,
    output logic                                    m_tlast,
    input  wire logic                               cfg_we,
    input  wire logic [fdpa_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [fdpa_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int SLOT_W = (DROP_SLOTS > 1) ? $clog2(DROP_SLOTS) : 1;
    localparam int CNT_W  = $clog2(DROP_SLOTS + 1);
    localparam logic [CNT_W-1:0] CNT_END = CNT_W'(DROP_SLOTS);
    localparam int SUM_W  = fdpa_pkg::COORD_W + 1;
    localparam logic [SUM_W-1:0] HEIGHT_L = SUM_W'(GRID_HEIGHT);
    localparam logic [SUM_W-1:0] WIDTH_L  = SUM_W'(GRID_WIDTH);
    localparam logic [fdpa_pkg::COORD_W-1:0] COL_MAX = fdpa_pkg::COORD_W'(GRID_WIDTH - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_MOVE,
        ST_SPAWN,
        ST_FINISH
    } state_t;

    // configuration
    logic [fdpa_pkg::CHANCE_W-1:0] chance_one_reg, chance_two_reg, chance_three_reg;
    logic [fdpa_pkg::SPEED_W-1:0]  speed_one_reg, speed_two_reg, speed_three_reg;

    // per-tick latched request
    state_t                         state_reg, state_next;
    logic [CNT_W-1:0]               cnt_reg, cnt_next;
    logic [fdpa_pkg::COLOR_W-1:0]   color_reg, color_next;
    logic [fdpa_pkg::CHANCE_W-1:0]  chance_reg, chance_next;
    logic [fdpa_pkg::SPEED_W-1:0]   speed_reg, speed_next;
    logic [fdpa_pkg::CHANCE_W-1:0]  draw_reg, draw_next;
    logic [fdpa_pkg::COORD_W-1:0]   col_reg, col_next;
    logic                           free_found_reg, free_found_next;
    logic [SLOT_W-1:0]              free_idx_reg, free_idx_next;

    // drop state
    logic [DROP_SLOTS-1:0]          live_reg, live_next;
    logic [fdpa_pkg::COORD_W-1:0]   col_mem [DROP_SLOTS];
    logic [fdpa_pkg::COORD_W-1:0]   row_mem [DROP_SLOTS];
    logic                           mem_we;
    logic [SLOT_W-1:0]              mem_addr;
    logic [fdpa_pkg::COORD_W-1:0]   mem_col_wd, mem_row_wd;

    // result path
    fdpa_pkg::pix_res_t             hold_reg, hold_next;
    logic                           hold_valid_reg, hold_valid_next;
    fdpa_pkg::pix_res_t             out_reg, out_next;
    logic                           out_valid_reg, out_valid_next;
    logic                           out_last_reg, out_last_next;

    logic [SLOT_W-1:0]              slot_idx;
    logic [fdpa_pkg::COORD_W-1:0]   rd_col_reg, rd_row_reg;
    logic [SUM_W-1:0]               row_sum;
    logic                           out_free, can_emit, emit;
    fdpa_pkg::pix_res_t             emit_res;
    logic [fdpa_pkg::MODE_W-1:0]    in_mode;
    logic [fdpa_pkg::CHANCE_W-1:0]  in_draw;
    logic [fdpa_pkg::COORD_W-1:0]   in_col;

    assign in_mode = s_tdata[2:0];
    assign in_draw = s_tdata[9:3];
    assign in_col  = s_tdata[14:10];

    assign slot_idx = cnt_reg[SLOT_W-1:0];
    // the shared unit: row advance and bottom-edge compare
    assign row_sum  = {1'b0, rd_row_reg} + {1'b0, speed_reg};

    assign out_free = !out_valid_reg || m_tready;
    // a new pixel displaces the held one into the output register
    assign can_emit = !hold_valid_reg || out_free;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0, out_reg.color, out_reg.y, out_reg.x};
    assign m_tuser  = out_reg.write;
    assign m_tlast  = out_last_reg;

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        color_next      = color_reg;
        chance_next     = chance_reg;
        speed_next      = speed_reg;
        draw_next       = draw_reg;
        col_next        = col_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        live_next       = live_reg;
        mem_we          = 1'b0;
        mem_addr        = slot_idx;
        mem_col_wd      = rd_col_reg;
        mem_row_wd      = rd_row_reg;
        emit            = 1'b0;
        emit_res        = '0;
        hold_next       = hold_reg;
        hold_valid_next = hold_valid_reg;
        out_next        = out_reg;
        out_last_next   = out_last_reg;
        out_valid_next  = m_tready ? 1'b0 : out_valid_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cnt_next        = '0;
                    free_found_next = 1'b0;
                    free_idx_next   = '0;
                    draw_next       = in_draw;
                    col_next        = ({1'b0, in_col} >= WIDTH_L) ? COL_MAX : in_col;
                    state_next      = ST_SCAN;
                    case (in_mode)
                        fdpa_pkg::MODE_WAIT:
                        begin
                            color_next  = fdpa_pkg::COLOR_BLUE;
                            chance_next = chance_one_reg >> 1;
                            speed_next  = speed_one_reg;
                        end
                        fdpa_pkg::MODE_FIRST:
                        begin
                            color_next  = fdpa_pkg::COLOR_BLUE;
                            chance_next = chance_one_reg;
                            speed_next  = speed_one_reg;
                        end
                        fdpa_pkg::MODE_SECOND:
                        begin
                            color_next  = fdpa_pkg::COLOR_CYAN;
                            chance_next = chance_two_reg;
                            speed_next  = speed_two_reg;
                        end
                        fdpa_pkg::MODE_THIRD:
                        begin
                            color_next  = fdpa_pkg::COLOR_WHITE;
                            chance_next = chance_three_reg;
                            speed_next  = speed_three_reg;
                        end
                        default:
                        begin
                            // no rain: tick yields only the marker
                            color_next  = fdpa_pkg::COLOR_BLACK;
                            chance_next = '0;
                            speed_next  = '0;
                            state_next  = ST_FINISH;
                        end
                    endcase
                end
            end

            ST_SCAN:
            begin
                if (cnt_reg == CNT_END)
                begin
                    state_next = ST_SPAWN;
                end
                else if (live_reg[slot_idx])
                begin
                    if (can_emit)
                    begin
                        emit       = 1'b1;
                        emit_res   = '{write: 1'b1, color: fdpa_pkg::COLOR_BLACK,
                                       y: rd_row_reg, x: rd_col_reg};
                        state_next = ST_MOVE;
                    end
                end
                else
                begin
                    if (!free_found_reg)
                    begin
                        free_found_next = 1'b1;
                        free_idx_next   = slot_idx;
                    end
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            ST_MOVE:
            begin
                if (row_sum >= HEIGHT_L)
                begin
                    // drop leaves the grid; slot is free for this tick's spawn
                    live_next[slot_idx] = 1'b0;
                    if (!free_found_reg)
                    begin
                        free_found_next = 1'b1;
                        free_idx_next   = slot_idx;
                    end
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = ST_SCAN;
                end
                else if (can_emit)
                begin
                    mem_we     = 1'b1;
                    mem_row_wd = row_sum[fdpa_pkg::COORD_W-1:0];
                    emit       = 1'b1;
                    emit_res   = '{write: 1'b1, color: color_reg,
                                   y: row_sum[fdpa_pkg::COORD_W-1:0], x: rd_col_reg};
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = ST_SCAN;
                end
            end

            ST_SPAWN:
            begin
                if ((draw_reg < chance_reg) && free_found_reg)
                begin
                    if (can_emit)
                    begin
                        mem_we                  = 1'b1;
                        mem_addr                = free_idx_reg;
                        mem_col_wd              = col_reg;
                        mem_row_wd              = '0;
                        live_next[free_idx_reg] = 1'b1;
                        emit                    = 1'b1;
                        emit_res                = '{write: 1'b1, color: color_reg,
                                                    y: '0, x: col_reg};
                        state_next              = ST_FINISH;
                    end
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end

            ST_FINISH:
            begin
                if (out_free)
                begin
                    // flush the held pixel as last, or send the empty marker
                    out_valid_next  = 1'b1;
                    out_next        = hold_valid_reg ? hold_reg : '0;
                    out_last_next   = 1'b1;
                    hold_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (emit)
        begin
            if (hold_valid_reg)
            begin
                out_valid_next = 1'b1;
                out_next       = hold_reg;
                out_last_next  = 1'b0;
            end
            hold_next       = emit_res;
            hold_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            cnt_reg          <= '0;
            color_reg        <= '0;
            chance_reg       <= '0;
            speed_reg        <= '0;
            draw_reg         <= '0;
            col_reg          <= '0;
            free_found_reg   <= 1'b0;
            free_idx_reg     <= '0;
            live_reg         <= '0;
            hold_reg         <= '0;
            hold_valid_reg   <= 1'b0;
            out_reg          <= '0;
            out_valid_reg    <= 1'b0;
            out_last_reg     <= 1'b0;
            chance_one_reg   <= 7'd10;
            speed_one_reg    <= 5'd1;
            chance_two_reg   <= 7'd20;
            speed_two_reg    <= 5'd1;
            chance_three_reg <= 7'd30;
            speed_three_reg  <= 5'd2;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            color_reg      <= color_next;
            chance_reg     <= chance_next;
            speed_reg      <= speed_next;
            draw_reg       <= draw_next;
            col_reg        <= col_next;
            free_found_reg <= free_found_next;
            free_idx_reg   <= free_idx_next;
            live_reg       <= live_next;
            hold_reg       <= hold_next;
            hold_valid_reg <= hold_valid_next;
            out_reg        <= out_next;
            out_valid_reg  <= out_valid_next;
            out_last_reg   <= out_last_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    fdpa_pkg::REG_CHANCE_ONE:   chance_one_reg   <= cfg_data;
                    fdpa_pkg::REG_SPEED_ONE:    speed_one_reg    <= cfg_data[4:0];
                    fdpa_pkg::REG_CHANCE_TWO:   chance_two_reg   <= cfg_data;
                    fdpa_pkg::REG_SPEED_TWO:    speed_two_reg    <= cfg_data[4:0];
                    fdpa_pkg::REG_CHANCE_THREE: chance_three_reg <= cfg_data;
                    fdpa_pkg::REG_SPEED_THREE:  speed_three_reg  <= cfg_data[4:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // drop position store, one write port; read data registered for the
    // slot the walk looks at next
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            col_mem[mem_addr] <= mem_col_wd;
            row_mem[mem_addr] <= mem_row_wd;
        end
        rd_col_reg <= col_mem[cnt_next[SLOT_W-1:0]];
        rd_row_reg <= row_mem[cnt_next[SLOT_W-1:0]];
    end

    // a pixel is only ever held mid-tick
    assert property (@(posedge clk) disable iff (!rst_n)
        hold_valid_reg |-> (state_reg != ST_IDLE))
        else $error("held pixel outside a tick");

    // the empty marker always closes its tick
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |-> m_tlast)
        else $error("marker without last flag");

    // a no-rain tick goes straight to the flush
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && (in_mode > fdpa_pkg::MODE_THIRD))
        |=> (state_reg == ST_FINISH))
        else $error("no-rain tick walked the slots");

    // slot walk never runs past the end
    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_END)
        else $error("slot counter overrun");

endmodule

`default_nettype wire
